@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl files (included by polygon_scanline_span_fill_unit)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on aclk, masked while in reset
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// concurrent check that also runs during reset
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/psf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg
// shared constants and types for the scanline span fill unit
// ----------------------------------------------------------------------------
package psf_pkg;
    localparam int MaxVerts  = 16;
    localparam int CoordBits = 12;
    localparam int IdxBits   = $clog2(MaxVerts);
    localparam int CntBits   = $clog2(MaxVerts + 1);
    localparam int CfgBits   = 5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_FILL = 1'b1;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef logic [CoordBits-1:0] coord_t;

    // divider request / reply
    typedef struct packed {
        logic   start;
        coord_t num;   // (y - yl), unsigned
        coord_t den;   // yh - yl, nonzero
        coord_t mag;   // |xh - xl|
    } div_req_t;

    typedef struct packed {
        logic   done;
        coord_t quo;   // floor(num*mag/den)
    } div_rsp_t;
endpackage

@@ rtl/psf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_ram
// generic single port ram, registered read
// ----------------------------------------------------------------------------
module psf_ram #(
    parameter int Width = 12,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end
    assign rdata = rdata_reg;
endmodule

@@ rtl/psf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_div
// multiply then restoring divide, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psf_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  psf_pkg::div_req_t req,
    output psf_pkg::div_rsp_t rsp
);
    localparam int PW = 2 * psf_pkg::CoordBits;
    localparam int SW = $clog2(PW + 2);

    logic [PW-1:0]                 prod_reg, prod_next;
    logic [psf_pkg::CoordBits:0]   rem_reg, rem_next;
    logic [PW-1:0]                 quo_reg, quo_next;
    psf_pkg::coord_t               den_reg, den_next;
    logic [SW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [psf_pkg::CoordBits:0]   trial;

    always_comb begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[psf_pkg::CoordBits-1:0], prod_reg[PW-1]};
        if (req.start) begin
            prod_next = req.num * req.mag;
            rem_next  = '0;
            quo_next  = '0;
            den_next  = req.den;
            cnt_next  = SW'(PW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {prod_reg[PW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[PW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[PW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg[psf_pkg::CoordBits-1:0];
endmodule

@@ rtl/polygon_scanline_span_fill_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_unit
// scanline polygon fill: vertex store, edge walk, crossing sort, span output
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request per transaction: a vertex load (req_type 0)
//   writes vertex_x/vertex_y into slot vertex_index, a fill (req_type 1) walks
//   the closed edge list for scanline scan_y
//   m_ channel returns spans left to right, span_last on the final one; a
//   scanline crossing no edge gives one transaction with span_empty set
//   vertex_count is written over the apb port at address 0
// fill sequence:
//   a load is taken and s_ready stays high; a fill walks every edge (read a,
//   read b, test), runs each crossing edge through the shared bit-serial
//   divider, insertion sorts the n crossings through the crossing ram and
//   then sends the spans; s_ready stays low until the fill returns to idle,
//   so the next request waits
// reset: synchronous, aresetn low; vertex_count and m_valid clear and the sequencer goes idle, stores are undefined
// stall: m_ready low holds the span register and the sequencer waits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module polygon_scanline_span_fill_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [3:0]  s_vertex_index,
    input  logic [11:0] s_vertex_x,
    input  logic [11:0] s_vertex_y,
    input  logic [11:0] s_scan_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_span_y,
    output logic [11:0] m_span_x_start,
    output logic [11:0] m_span_x_end,
    output logic        m_span_empty,
    output logic        m_span_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = psf_pkg::CoordBits;
    localparam int IW = psf_pkg::IdxBits;
    localparam int NW = psf_pkg::CntBits;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDA   = 4'd1;  // read vertex i
    localparam logic [3:0] ST_RDB   = 4'd2;  // capture a, read vertex next
    localparam logic [3:0] ST_EDGE  = 4'd3;  // b on ram output, test edge
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_SRDV  = 4'd5;  // sort: read key at i
    localparam logic [3:0] ST_SRDJ  = 4'd6;  // sort: read j-1
    localparam logic [3:0] ST_SCMP  = 4'd7;  // sort: compare/shift
    localparam logic [3:0] ST_ORDA  = 4'd8;  // output: read start
    localparam logic [3:0] ST_ORDB  = 4'd9;  // output: read end
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_KEYLD = 4'd11; // sort: capture key

    logic [3:0]   st_reg, st_next;
    logic [4:0]   vcnt_reg;
    logic [NW-1:0] cnt_reg, cnt_next;     // saturated vertex count
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] nc_reg, nc_next;
    psf_pkg::coord_t sy_reg, sy_next;
    psf_pkg::coord_t xa_reg, xa_next, ya_reg, ya_next;
    psf_pkg::coord_t xl_reg, xl_next, neg_reg, neg_next;
    psf_pkg::coord_t key_reg, key_next;
    psf_pkg::coord_t xs_reg, xs_next;
    logic          m_valid_reg, m_valid_next;
    psf_pkg::coord_t my_reg, my_next;
    psf_pkg::coord_t mxs_reg, mxs_next, mxe_reg, mxe_next;
    logic          mempty_reg, mempty_next, mlast_reg, mlast_next;

    // vertex rams
    logic          v_we;
    logic [IW-1:0] v_addr;
    psf_pkg::coord_t vx_wd, vy_wd, vx_rd, vy_rd;
    // crossing ram
    logic          c_we;
    logic [IW-1:0] c_addr;
    psf_pkg::coord_t c_wd, c_rd;

    psf_pkg::div_req_t dreq;
    psf_pkg::div_rsp_t drsp;

    psf_ram #(.Width(CW), .Depth(psf_pkg::MaxVerts)) u_vx_ram (
        .aclk(aclk), .we(v_we), .addr(v_addr), .wdata(vx_wd), .rdata(vx_rd));
    psf_ram #(.Width(CW), .Depth(psf_pkg::MaxVerts)) u_vy_ram (
        .aclk(aclk), .we(v_we), .addr(v_addr), .wdata(vy_wd), .rdata(vy_rd));
    psf_ram #(.Width(CW), .Depth(psf_pkg::MaxVerts)) u_cross_ram (
        .aclk(aclk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
    psf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // apb: always ready, single register
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == psf_pkg::REG_VERTEX_COUNT)
                    && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == psf_pkg::REG_VERTEX_COUNT) ? {27'd0, vcnt_reg} : 32'd0;

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    // span scanline has its own register so a new fill cannot disturb a waiting span
    assign m_span_y = my_reg;
    assign m_span_x_start = mxs_reg;
    assign m_span_x_end = mxe_reg;
    assign m_span_empty = mempty_reg;
    assign m_span_last = mlast_reg;

    // i plus one; ST_RDB wraps it to slot 0 to close the list
    logic [NW-1:0] i_inc;
    assign i_inc = i_reg + 1'b1;

    psf_pkg::coord_t xb_w, yb_w;
    logic          b_up;
    assign xb_w = vx_rd;
    assign yb_w = vy_rd;
    assign b_up = (ya_reg < yb_w);

    always_comb begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        nc_next   = nc_reg;
        sy_next   = sy_reg;
        xa_next   = xa_reg;
        ya_next   = ya_reg;
        xl_next   = xl_reg;
        neg_next  = neg_reg;
        key_next  = key_reg;
        xs_next   = xs_reg;
        m_valid_next = m_valid_reg;
        my_next   = my_reg;
        mxs_next  = mxs_reg;
        mxe_next  = mxe_reg;
        mempty_next = mempty_reg;
        mlast_next  = mlast_reg;
        v_we   = 1'b0;
        v_addr = i_reg[IW-1:0];
        vx_wd  = s_vertex_x;
        vy_wd  = s_vertex_y;
        c_we   = 1'b0;
        c_addr = i_reg[IW-1:0];
        c_wd   = key_reg;
        dreq   = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == psf_pkg::REQ_LOAD) begin
                        v_we   = 1'b1;
                        v_addr = s_vertex_index;
                    end else begin
                        sy_next  = s_scan_y;
                        cnt_next = (vcnt_reg > 5'(psf_pkg::MaxVerts))
                                   ? NW'(psf_pkg::MaxVerts) : NW'(vcnt_reg);
                        i_next   = '0;
                        nc_next  = '0;
                        st_next  = ST_RDA;
                    end
                end
            end
            ST_RDA: begin
                if (i_reg >= cnt_reg || cnt_reg < NW'(2)) begin
                    i_next  = NW'(1);
                    st_next = ST_SRDV;
                end else begin
                    v_addr  = i_reg[IW-1:0];
                    st_next = ST_RDB;
                end
            end
            ST_RDB: begin
                xa_next = vx_rd;
                ya_next = vy_rd;
                v_addr  = (i_inc == cnt_reg) ? '0 : i_inc[IW-1:0];
                st_next = ST_EDGE;
            end
            ST_EDGE: begin
                if (ya_reg == yb_w) begin
                    i_next  = i_inc;
                    st_next = ST_RDA;
                end else begin
                    if (b_up) begin
                        // lower end is a
                        if (ya_reg <= sy_reg && sy_reg < yb_w) begin
                            xl_next  = xa_reg;
                            neg_next = {CW{(xb_w < xa_reg)}};
                            dreq.start = 1'b1;
                            dreq.num = sy_reg - ya_reg;
                            dreq.den = yb_w - ya_reg;
                            dreq.mag = (xb_w < xa_reg) ? xa_reg - xb_w : xb_w - xa_reg;
                            st_next = ST_DIV;
                        end else begin
                            i_next  = i_inc;
                            st_next = ST_RDA;
                        end
                    end else begin
                        if (yb_w <= sy_reg && sy_reg < ya_reg) begin
                            xl_next  = xb_w;
                            neg_next = {CW{(xa_reg < xb_w)}};
                            dreq.start = 1'b1;
                            dreq.num = sy_reg - yb_w;
                            dreq.den = ya_reg - yb_w;
                            dreq.mag = (xa_reg < xb_w) ? xb_w - xa_reg : xa_reg - xb_w;
                            st_next = ST_DIV;
                        end else begin
                            i_next  = i_inc;
                            st_next = ST_RDA;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (drsp.done) begin
                    // truncation toward zero: subtract magnitude when falling
                    c_we    = 1'b1;
                    c_addr  = nc_reg[IW-1:0];
                    c_wd    = neg_reg[0] ? xl_reg - drsp.quo : xl_reg + drsp.quo;
                    nc_next = nc_reg + 1'b1;
                    i_next  = i_inc;
                    st_next = ST_RDA;
                end
            end
            // insertion sort held in the crossing ram
            ST_SRDV: begin
                if (i_reg >= nc_reg) begin
                    i_next  = '0;
                    st_next = ST_ORDA;
                end else begin
                    c_addr  = i_reg[IW-1:0];
                    st_next = ST_KEYLD;
                end
            end
            ST_KEYLD: begin
                key_next = c_rd;
                j_next   = i_reg;
                st_next  = ST_SRDJ;
            end
            ST_SRDJ: begin
                if (j_reg == '0) begin
                    c_we    = 1'b1;
                    c_addr  = '0;
                    i_next  = i_inc;
                    st_next = ST_SRDV;
                end else begin
                    c_addr  = IW'(j_reg - 1'b1);
                    st_next = ST_SCMP;
                end
            end
            ST_SCMP: begin
                c_we   = 1'b1;
                c_addr = j_reg[IW-1:0];
                if (c_rd > key_reg) begin
                    c_wd    = c_rd;
                    j_next  = j_reg - 1'b1;
                    st_next = ST_SRDJ;
                end else begin
                    i_next  = i_inc;
                    st_next = ST_SRDV;
                end
            end
            ST_ORDA: begin
                if (!m_valid_reg || m_ready) begin
                    if (nc_reg == '0) begin
                        m_valid_next = 1'b1;
                        my_next  = sy_reg;
                        mxs_next = '0;
                        mxe_next = '0;
                        mempty_next = 1'b1;
                        mlast_next  = 1'b1;
                        st_next = ST_IDLE;
                    end else if (i_reg >= nc_reg) begin
                        st_next = ST_IDLE;
                    end else begin
                        c_addr  = i_reg[IW-1:0];
                        st_next = ST_ORDB;
                    end
                end
            end
            ST_ORDB: begin
                xs_next = c_rd;
                c_addr  = IW'(i_inc);
                st_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid_next = 1'b1;
                my_next  = sy_reg;
                mxs_next = xs_reg;
                mxe_next = (i_inc < nc_reg) ? c_rd : xs_reg;
                mempty_next = 1'b0;
                mlast_next  = (i_reg + NW'(2) >= nc_reg);
                i_next   = i_reg + NW'(2);
                st_next  = ST_ORDA;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            vcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                vcnt_reg <= pwdata[4:0];
            end
        end
        cnt_reg    <= cnt_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        nc_reg     <= nc_next;
        sy_reg     <= sy_next;
        xa_reg     <= xa_next;
        ya_reg     <= ya_next;
        xl_reg     <= xl_next;
        neg_reg    <= neg_next;
        key_reg    <= key_next;
        xs_reg     <= xs_next;
        my_reg     <= my_next;
        mxs_reg    <= mxs_next;
        mxe_reg    <= mxe_next;
        mempty_reg <= mempty_next;
        mlast_reg  <= mlast_next;
    end

    // a new span never overwrites a waiting one
    `CHK_CLK(a_no_overwrite, (m_valid && !m_ready) |=> (m_valid && $stable(m_span_x_start)), "span dropped")
    // input is only taken while the sequencer is idle
    `CHK_CLK(a_busy_no_accept, (st_reg != ST_IDLE) |-> !s_ready, "accept while busy")
    // crossing count never exceeds the vertex count
    `CHK_CLK(a_nc_bound, (nc_reg <= cnt_reg) || (st_reg == ST_IDLE), "crossing overflow")
endmodule
